// ----- hw/rtl/slrg_pkg.sv -----
// Shared types and constants of the subtractive lagged random generator.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package slrg_pkg;

	localparam int LagLength = 55;
	localparam int ValueW    = 30;
	localparam int SeedW     = 28;
	localparam int AddrW     = 6;

	localparam logic [ValueW-1:0] ModBig   = 30'd1000000000;
	localparam logic [SeedW-1:0]  SeedBase = 28'd161803398;

	// seeding walks the table in steps of 21 modulo 55
	localparam logic [AddrW-1:0] SeedStride = 6'd21;
	// second read pointer start and warm-up partner distance
	localparam logic [AddrW-1:0] LagOffset  = 6'd31;
	localparam logic [AddrW-1:0] LastEntry  = 6'd55;
	localparam logic [AddrW-1:0] FirstEntry = 6'd1;
	// entries above this take their warm-up partner from below
	localparam logic [AddrW-1:0] WarmSplit  = 6'd24;
	localparam logic [AddrW-1:0] LastFill   = 6'd54;
	localparam logic [1:0]       LastPass   = 2'd3;

	// table write port
	typedef struct packed {
		logic              en;
		logic [AddrW-1:0]  addr;
		logic [ValueW-1:0] data;
	} slrg_wr_t;

endpackage

// ----- hw/rtl/slrg_submod.sv -----
// Shared subtract-modulo unit: y = (a - b) mod 10^9 for a, b below 10^9.
// Depends on slrg_pkg.
`timescale 1ns / 1ps

module slrg_submod (
	input  logic [slrg_pkg::ValueW-1:0] a,
	input  logic [slrg_pkg::ValueW-1:0] b,
	output logic [slrg_pkg::ValueW-1:0] y
);
	import slrg_pkg::*;

	logic [ValueW:0] diff;
	logic [ValueW:0] wrapped;

	// one subtract, one correcting add when it goes negative
	assign diff    = {1'b0, a} - {1'b0, b};
	assign wrapped = diff + {1'b0, ModBig};
	assign y       = diff[ValueW] ? wrapped[ValueW-1:0] : diff[ValueW-1:0];

endmodule

// ----- hw/rtl/slrg_table.sv -----
// Lag table: one write port and two read ports with registered read data.
// Depends on slrg_pkg.
`timescale 1ns / 1ps

module slrg_table (
	input  logic                        clk,
	input  slrg_pkg::slrg_wr_t          wr,
	input  logic [slrg_pkg::AddrW-1:0]  raddr_a,
	input  logic [slrg_pkg::AddrW-1:0]  raddr_b,
	output logic [slrg_pkg::ValueW-1:0] rdata_a,
	output logic [slrg_pkg::ValueW-1:0] rdata_b
);
	import slrg_pkg::*;

	// entries 1..55 used, entry 0 never touched
	logic [ValueW-1:0] mem_q [0:LagLength];

	// write port
	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem_q[wr.addr] <= wr.data;
		end
	end

	// registered reads
	always_ff @(posedge clk) begin
		rdata_a <= mem_q[raddr_a];
		rdata_b <= mem_q[raddr_b];
	end

endmodule

// ----- hw/rtl/subtractive_lagged_random_generator_core.sv -----
// Top level of the subtractive lagged random generator: sequencer, pointers,
// seed logic. Depends on slrg_pkg, slrg_submod and slrg_table.
`timescale 1ns / 1ps

// Usage
// Input channel (in_valid / in_stall) carries one draw request with the restart
// bit. Output channel (out_valid / out_stall) returns one 30-bit random_value,
// 0 .. 999999999, for every request. The seed register is written through
// cfg_write_en / cfg_write_data; the user must write it only while the
// block is idle, which the block itself does not enforce. It takes effect
// at the next reseed.
// A normal draw goes from accept through a table read, then subtract and
// write-back into the output register. A draw that reseeds (first draw
// after reset or restart set) first places the seed, fills the other 54
// entries and runs four warm-up passes over the 55 entries, each a table
// read, then subtract and write-back through the one subtract unit; then
// it takes the normal draw steps.
// in_stall is high while a draw is in work; a new draw is taken as soon as
// the previous one has reached the output register.
// Reset clears the pointers (0 and 31), the seeded flag, the seed register
// and the output valid. The table is not cleared; seeding fills entries 1..55.
// A stalled receiver holds the result; a finished draw waits in its last
// step until the output register frees up, with the table unchanged.
module subtractive_lagged_random_generator_core (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_write_en,
	input  logic [slrg_pkg::SeedW-1:0]  cfg_write_data,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic                        restart,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [slrg_pkg::ValueW-1:0] random_value
);
	import slrg_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SEED_TOP,
		ST_SEED_FILL,
		ST_WARM_READ,
		ST_WARM_SUB,
		ST_DRAW_READ,
		ST_DRAW_SUB
	} state_t;

	state_t            state_q;
	logic [SeedW-1:0]  seed_q;
	logic              seeded_q;
	logic [AddrW-1:0]  first_ptr_q;
	logic [AddrW-1:0]  second_ptr_q;
	logic [AddrW-1:0]  addr_a_q;
	logic [AddrW-1:0]  addr_b_q;
	logic [ValueW-1:0] mj_q;
	logic [ValueW-1:0] mk_q;
	logic [AddrW-1:0]  slot_q;
	logic [AddrW-1:0]  fill_cnt_q;
	logic [1:0]        pass_q;
	logic              out_valid_q;
	logic [ValueW-1:0] random_value_q;

	logic              accept;
	logic              out_free;
	logic [ValueW-1:0] rd_a;
	logic [ValueW-1:0] rd_b;
	logic [ValueW-1:0] sub_a;
	logic [ValueW-1:0] sub_b;
	logic [ValueW-1:0] sub_y;
	slrg_wr_t          wr;
	logic [AddrW-1:0]  first_next;
	logic [AddrW-1:0]  second_next;
	logic [AddrW:0]    slot_sum;
	logic [AddrW-1:0]  slot_next;
	logic [AddrW-1:0]  warm_idx_next;
	logic [AddrW-1:0]  warm_partner_next;
	logic [SeedW-1:0]  seed_mag;

	assign accept       = in_valid && (state_q == ST_IDLE);
	assign in_stall     = (state_q != ST_IDLE);
	assign out_free     = !out_valid_q || !out_stall;
	assign out_valid    = out_valid_q;
	assign random_value = random_value_q;

	// pointer step, 55 wraps to 1
	assign first_next  = (first_ptr_q >= LastEntry) ? FirstEntry : first_ptr_q + FirstEntry;
	assign second_next = (second_ptr_q >= LastEntry) ? FirstEntry : second_ptr_q + FirstEntry;

	// seeding slot walk modulo 55
	assign slot_sum  = {1'b0, slot_q} + {1'b0, SeedStride};
	assign slot_next = (slot_sum >= {1'b0, LastEntry}) ? slot_sum[AddrW-1:0] - LastEntry
	                                                   : slot_sum[AddrW-1:0];

	// next warm-up entry and its partner 1 + (i + 30) mod 55
	assign warm_idx_next     = (addr_a_q == LastEntry) ? FirstEntry : addr_a_q + FirstEntry;
	assign warm_partner_next = (warm_idx_next <= WarmSplit) ? warm_idx_next + LagOffset
	                                                        : warm_idx_next - WarmSplit;

	// seed magnitude below 10^9 by range
	assign seed_mag = (seed_q <= SeedBase) ? SeedBase - seed_q : seed_q - SeedBase;

	// shared subtract unit operand select
	always_comb begin
		if (state_q == ST_SEED_FILL) begin
			sub_a = mj_q;
			sub_b = mk_q;
		end else begin
			sub_a = rd_a;
			sub_b = rd_b;
		end
	end

	slrg_submod u_submod (
		.a (sub_a),
		.b (sub_b),
		.y (sub_y)
	);

	// table write select
	always_comb begin
		wr.en   = 1'b0;
		wr.addr = addr_a_q;
		wr.data = sub_y;
		unique case (state_q)
			ST_SEED_TOP: begin
				wr.en   = 1'b1;
				wr.addr = LastEntry;
				wr.data = mj_q;
			end
			ST_SEED_FILL: begin
				wr.en   = 1'b1;
				wr.addr = slot_q;
				wr.data = mk_q;
			end
			ST_WARM_SUB: begin
				wr.en = 1'b1;
			end
			ST_DRAW_SUB: begin
				wr.en = out_free;
			end
			default: begin
				wr.en = 1'b0;
			end
		endcase
	end

	slrg_table u_table (
		.clk     (clk),
		.wr      (wr),
		.raddr_a (addr_a_q),
		.raddr_b (addr_b_q),
		.rdata_a (rd_a),
		.rdata_b (rd_b)
	);

	// seed register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seed_q <= '0;
		end else if (cfg_write_en) begin
			seed_q <= cfg_write_data;
		end
	end

	// sequencer, pointers and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			seeded_q     <= 1'b0;
			first_ptr_q  <= '0;
			second_ptr_q <= LagOffset;
			out_valid_q  <= 1'b0;
			addr_a_q     <= '0;
			addr_b_q     <= '0;
			fill_cnt_q   <= '0;
			pass_q       <= '0;
		end else begin
			// result beat taken, unless a new one loads in the same cycle
			if (out_valid_q && !out_stall && state_q != ST_DRAW_SUB) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (restart || !seeded_q) begin
							mj_q    <= {{(ValueW-SeedW){1'b0}}, seed_mag};
							state_q <= ST_SEED_TOP;
						end else begin
							first_ptr_q  <= first_next;
							second_ptr_q <= second_next;
							addr_a_q     <= first_next;
							addr_b_q     <= second_next;
							state_q      <= ST_DRAW_READ;
						end
					end
				end
				ST_SEED_TOP: begin
					mk_q       <= {{(ValueW-1){1'b0}}, 1'b1};
					slot_q     <= SeedStride;
					fill_cnt_q <= FirstEntry;
					state_q    <= ST_SEED_FILL;
				end
				ST_SEED_FILL: begin
					mk_q       <= sub_y;
					mj_q       <= mk_q;
					slot_q     <= slot_next;
					fill_cnt_q <= fill_cnt_q + FirstEntry;
					if (fill_cnt_q == LastFill) begin
						addr_a_q <= FirstEntry;
						addr_b_q <= FirstEntry + LagOffset;
						pass_q   <= '0;
						state_q  <= ST_WARM_READ;
					end
				end
				ST_WARM_READ: begin
					state_q <= ST_WARM_SUB;
				end
				ST_WARM_SUB: begin
					if (addr_a_q == LastEntry && pass_q == LastPass) begin
						// warm-up done, draw from pointers 1 and 32
						seeded_q     <= 1'b1;
						first_ptr_q  <= FirstEntry;
						second_ptr_q <= LagOffset + FirstEntry;
						addr_a_q     <= FirstEntry;
						addr_b_q     <= LagOffset + FirstEntry;
						state_q      <= ST_DRAW_READ;
					end else begin
						if (addr_a_q == LastEntry) begin
							pass_q <= pass_q + 2'd1;
						end
						addr_a_q <= warm_idx_next;
						addr_b_q <= warm_partner_next;
						state_q  <= ST_WARM_READ;
					end
				end
				ST_DRAW_READ: begin
					state_q <= ST_DRAW_SUB;
				end
				ST_DRAW_SUB: begin
					if (out_free) begin
						out_valid_q    <= 1'b1;
						random_value_q <= sub_y;
						state_q        <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

// ----- verif/slrg_checker.sv -----
// Checker for the subtractive lagged random generator: tracks seed writes and
// draw beats, predicts each random_value and compares the result beats in order.
// Depends on slrg_pkg.
`timescale 1ns / 1ps

module slrg_checker (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_write_en,
	input  logic [slrg_pkg::SeedW-1:0]  cfg_write_data,
	input  logic                        in_valid,
	input  logic                        in_stall,
	input  logic                        restart,
	input  logic                        out_valid,
	input  logic                        out_stall,
	input  logic [slrg_pkg::ValueW-1:0] random_value,
	output int                          fail_count,
	output int                          pending,
	output int                          draws_checked,
	output int                          reseeds
);
	import slrg_pkg::*;

	localparam int MaxReports = 10;
	// warm-up partner of entry i is entry 1 + (i + WarmDist) mod 55
	localparam int WarmDist   = int'(LagOffset) - 1;
	localparam int WarmPasses = int'(LastPass) + 1;

	// predictor state
	logic [ValueW-1:0] lag_tbl [1:LagLength];
	logic [AddrW-1:0]  lead_ptr;
	logic [AddrW-1:0]  trail_ptr;
	logic              seeded;
	logic [SeedW-1:0]  seed_reg;

	// values still owed by the block, oldest first
	logic [ValueW-1:0] owed_values [$];
	logic [ValueW-1:0] owed;
	logic [ValueW-1:0] drawn;

	// difference modulo 10^9, both operands already in range
	function automatic logic [ValueW-1:0] mod_sub(input logic [ValueW-1:0] a,
		input logic [ValueW-1:0] b);
		logic [31:0] d;
		if (a >= b) begin
			d = {2'b00, a} - {2'b00, b};
		end else begin
			d = {2'b00, a} + {2'b00, ModBig} - {2'b00, b};
		end
		return d[ValueW-1:0];
	endfunction

	// pointers run 1..55 and wrap back to 1
	function automatic logic [AddrW-1:0] next_entry(input logic [AddrW-1:0] p);
		return (p >= LastEntry) ? FirstEntry : p + 1'b1;
	endfunction

	// fill the table from the seed, then stir it
	task automatic seed_table();
		logic [ValueW-1:0] mj;
		logic [ValueW-1:0] mk;
		logic [SeedW-1:0]  mag;
		logic [AddrW-1:0]  slot;
		logic [AddrW-1:0]  idx;
		logic [AddrW-1:0]  partner;
		int                i;
		int                pass;
		mag = (seed_reg <= SeedBase) ? SeedBase - seed_reg : seed_reg - SeedBase;
		mj = {2'b00, mag};
		lag_tbl[LastEntry] = mj;
		mk = ValueW'(1);
		for (i = 1; i < LagLength; i++) begin
			slot = AddrW'((int'(SeedStride) * i) % LagLength);
			lag_tbl[slot] = mk;
			mk = mod_sub(mj, mk);
			mj = lag_tbl[slot];
		end
		for (pass = 0; pass < WarmPasses; pass++) begin
			for (i = 1; i <= LagLength; i++) begin
				idx     = AddrW'(i);
				partner = AddrW'(1 + (i + WarmDist) % LagLength);
				lag_tbl[idx] = mod_sub(lag_tbl[idx], lag_tbl[partner]);
			end
		end
		lead_ptr  = '0;
		trail_ptr = LagOffset;
		seeded    = 1'b1;
		reseeds++;
	endtask

	task automatic report(input string msg);
		fail_count++;
		if (fail_count <= MaxReports) begin
			$display("[%0t] %s", $realtime, msg);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lead_ptr      = '0;
			trail_ptr     = LagOffset;
			seeded        = 1'b0;
			seed_reg      = '0;
			owed_values.delete();
			pending       = 0;
			fail_count    = 0;
			draws_checked = 0;
			reseeds       = 0;
		end else begin
			// seed register write
			if (cfg_write_en) begin
				seed_reg = cfg_write_data;
			end
			// result beat against the oldest owed value
			if (out_valid && !out_stall) begin
				if (owed_values.size() == 0) begin
					report($sformatf("unexpected result beat: random_value %0d", random_value));
				end else begin
					owed = owed_values.pop_front();
					draws_checked++;
					if (random_value !== owed) begin
						report($sformatf("draw %0d: random_value expected %0d, got %0d",
							draws_checked, owed, random_value));
					end
				end
			end
			// draw beat
			if (in_valid && !in_stall) begin
				if (restart || !seeded) begin
					seed_table();
				end
				lead_ptr  = next_entry(lead_ptr);
				trail_ptr = next_entry(trail_ptr);
				drawn = mod_sub(lag_tbl[lead_ptr], lag_tbl[trail_ptr]);
				lag_tbl[lead_ptr] = drawn;
				owed_values.push_back(drawn);
			end
			pending = owed_values.size();
		end
	end

endmodule

// ----- verif/subtractive_lagged_random_generator_core_tb.sv -----
// Testbench top for the subtractive lagged random generator: clock, reset,
// draw and seed stimulus, receiver stalls and verdict. Depends on slrg_pkg,
// slrg_checker and the core.
`timescale 1ns / 1ps

module subtractive_lagged_random_generator_core_tb;
	import slrg_pkg::*;

	localparam int IdleLimit  = 3000;
	localparam int PhaseCount = 8;
	localparam int PhaseDraws = 145;
	localparam logic [SeedW-1:0] SeedTop = '1;

	typedef enum int {StallNone, StallCoin, StallHeavy, StallPeriodic} stall_mode_t;

	logic              clk            = 1'b0;
	logic              arst_n         = 1'b0;
	logic              cfg_write_en   = 1'b0;
	logic [SeedW-1:0]  cfg_write_data = '0;
	logic              in_valid       = 1'b0;
	logic              restart        = 1'b0;
	logic              out_stall      = 1'b0;
	logic              in_stall;
	logic              out_valid;
	logic [ValueW-1:0] random_value;

	int fail_count;
	int pending;
	int draws_checked;
	int reseeds;
	int burst_left  = 0;
	int seed_writes = 0;
	int idle_cycles = 0;
	int stall_run   = 0;
	stall_mode_t stall_mode = StallNone;

	always #5 clk = ~clk;

	subtractive_lagged_random_generator_core u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_write_en  (cfg_write_en),
		.cfg_write_data(cfg_write_data),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.restart       (restart),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.random_value  (random_value)
	);

	slrg_checker u_chk (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_write_en  (cfg_write_en),
		.cfg_write_data(cfg_write_data),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.restart       (restart),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.random_value  (random_value),
		.fail_count    (fail_count),
		.pending       (pending),
		.draws_checked (draws_checked),
		.reseeds       (reseeds)
	);

	// receiver stall pattern, switching to a random mode after each run of random length
	always @(negedge clk) begin
		if (stall_run == 0) begin
			stall_mode = stall_mode_t'($urandom_range(0, 3));
			stall_run  = $urandom_range(16, 160);
		end
		stall_run--;
		case (stall_mode)
			StallNone: out_stall <= 1'b0;
			StallCoin: out_stall <= ($urandom_range(0, 1) != 0);
			StallHeavy: out_stall <= ($urandom_range(0, 7) != 0);
			default: out_stall <= stall_run[2];
		endcase
	end

	// watchdog on cycles without any beat
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
			idle_cycles <= 0;
		end else if (arst_n) begin
			idle_cycles <= idle_cycles + 1;
		end
		if (idle_cycles >= IdleLimit) begin
			$display("** subtractive_lagged_random_generator_core: FAILED **");
			$finish;
		end
	end

	// one draw beat, with bursts and gaps on the sender side
	task automatic send_draw(input logic reseed_bit);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 15);
			burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
				: $urandom_range(1, 30);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
		end
		in_valid <= 1'b1;
		restart  <= reseed_bit;
		do @(posedge clk); while (in_stall);
		@(negedge clk);
		burst_left--;
	endtask

	// hold the sender until every owed result has come back
	task automatic drain();
		in_valid <= 1'b0;
		while (pending != 0) @(negedge clk);
		@(negedge clk);
		burst_left = 0;
	endtask

	// seed register write, only while the block is idle
	task automatic write_seed(input logic [SeedW-1:0] seed);
		cfg_write_en   <= 1'b1;
		cfg_write_data <= seed;
		@(negedge clk);
		cfg_write_en   <= 1'b0;
		seed_writes++;
	endtask

	initial begin
		int               ph;
		int               n;
		int               draws;
		logic [SeedW-1:0] seed;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// first draw seeds from the reset seed, then restarts back to back
		send_draw(1'b0);
		send_draw(1'b0);
		send_draw(1'b0);
		send_draw(1'b1);
		send_draw(1'b1);
		send_draw(1'b0);
		// seed equal to the base constant gives a zero magnitude
		drain();
		write_seed(SeedBase);
		send_draw(1'b1);
		send_draw(1'b0);
		send_draw(1'b0);
		// seed above the base, held until the next restart
		drain();
		write_seed(SeedBase + 1'b1);
		send_draw(1'b0);
		send_draw(1'b1);
		send_draw(1'b0);
		// largest seed, then overwritten seeds before a restart
		drain();
		write_seed(SeedTop);
		send_draw(1'b1);
		send_draw(1'b0);
		drain();
		write_seed('0);
		write_seed(28'd1);
		send_draw(1'b1);
		send_draw(1'b0);
		send_draw(1'b1);

		// random phases: long runs with rare restarts so both pointers wrap
		for (ph = 0; ph < PhaseCount; ph++) begin
			drain();
			if ($urandom_range(0, 1) == 0) begin
				seed = SeedW'($urandom_range(0, int'(SeedBase)));
			end else begin
				seed = SeedW'($urandom);
			end
			write_seed(seed);
			draws = PhaseDraws + $urandom_range(0, 20);
			for (n = 0; n < draws; n++) begin
				if (n == 0) begin
					send_draw($urandom_range(0, 3) != 0);
				end else begin
					send_draw($urandom_range(0, 39) == 0);
				end
			end
		end

		drain();
		repeat (8) @(posedge clk);
		$display("covered %0d checked draws, %0d of them reseeding, across %0d seed writes",
			draws_checked, reseeds, seed_writes);
		if (fail_count == 0 && pending == 0) begin
			$display("** subtractive_lagged_random_generator_core: PASSED **");
		end else begin
			$display("** subtractive_lagged_random_generator_core: FAILED **");
		end
		$finish;
	end

endmodule
